/* src/perspective_warp_coord_macros.svh */
// Assertion macros shared by the perspective warp RTL.
// No dependencies; included inside module bodies that assert.
`ifndef PERSPECTIVE_WARP_COORD_MACROS_SVH
`define PERSPECTIVE_WARP_COORD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/pwc_pkg.sv */
// Types and constants for the perspective warp coordinate block.
// No dependencies; used by perspective_warp_coord.
package pwc_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int MIN_MAG   = 64;
	localparam int ROUND_HALF = 32768;

	// Denominator 65536 + (k*y >>> 16) needs 49 signed bits.
	localparam int DEN_W     = 2 * COORD_W - FRAC_BITS + 1;
	// Divisor magnitude after clamping to 2^32 (anything larger saturates).
	localparam int DIV_W     = 33;
	// Quotient of 2^32 by a divisor of at least 64 fits 27 bits.
	localparam int DIV_STEPS = 27;
	localparam int SCALE_W   = DIV_STEPS + 1;
	localparam int PROD_W    = COORD_W + SCALE_W;
	// Dividend bits above the quotient field: 2^32 >> 27.
	localparam int INIT_REM  = 32;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} coord_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] warped_x;
		logic signed [COORD_W-1:0] warped_y;
	} coord_out_t;

endpackage

/* src/perspective_warp_coord.sv */
// Perspective warp of a signed 32-bit coordinate pair: one word in and one word out per
// clock once the pipeline is full and the output is not stalled. The depth
// is set by the 2^32/denominator divider, a restoring divider with one quotient bit per
// stage over 27 stages; the strength multiply, denominator, clamp, sign restore, output
// multiply and rounding take the other six stages. The whole pipeline advances together
// and holds only while a finished word waits at the output. warp_strength is written
// through the cfg channel, which is always ready, and must only change between frames.
// Depends on pwc_pkg and perspective_warp_coord_macros.svh.
module perspective_warp_coord (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [31:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pwc_pkg::coord_in_t    in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pwc_pkg::coord_out_t   out_word
);
	import pwc_pkg::*;
	`include "perspective_warp_coord_macros.svh"

	localparam logic signed [DEN_W-1:0] DEN_ONE   = DEN_W'(65536);
	localparam logic [DEN_W-1:0]        DEN_LIMIT = DEN_W'(64'h1_0000_0000);
	localparam logic [DEN_W-1:0]        MAG_MIN   = DEN_W'(MIN_MAG);
	localparam logic [DIV_STEPS-1:0]    QUO_MAX   = DIV_STEPS'(1 << (DIV_STEPS - 1));

	logic signed [COORD_W-1:0] warp_strength_q;
	logic                      out_valid_q;
	coord_out_t                out_word_q;
	logic                      adv;

	// Stage registers.
	logic                        vld_s1, vld_s2, vld_s31, vld_s32;
	logic signed [2*COORD_W-1:0] prod_s1;
	logic signed [COORD_W-1:0]   x_s1, y_s1, x_s2, y_s2, x_s31, y_s31;
	logic signed [DEN_W-1:0]     denom_s2;
	logic signed [SCALE_W-1:0]   scale_s31;
	logic signed [PROD_W-1:0]    px_s32, py_s32;

	// Divider stages; index 0 is the clamp stage, index DIV_STEPS the last quotient bit.
	logic                      div_vld_s [DIV_STEPS+1];
	logic [DIV_W-1:0]          div_rem_s [DIV_STEPS+1];
	logic [DIV_W-1:0]          div_d_s   [DIV_STEPS+1];
	logic [DIV_STEPS-1:0]      div_quo_s [DIV_STEPS+1];
	logic                      div_neg_s [DIV_STEPS+1];
	logic signed [COORD_W-1:0] div_x_s   [DIV_STEPS+1];
	logic signed [COORD_W-1:0] div_y_s   [DIV_STEPS+1];

	logic                    den_neg;
	logic [DEN_W-1:0]        den_mag;
	logic [DIV_W-1:0]        div_d_in;
	logic signed [PROD_W-1:0] rnd_x, rnd_y;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warp_strength_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			warp_strength_q <= signed'(cfg_data);
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			div_vld_s[0] <= 1'b0;
			vld_s31      <= 1'b0;
			vld_s32      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			vld_s1       <= in_valid;
			vld_s2       <= vld_s1;
			div_vld_s[0] <= vld_s2;
			vld_s31      <= div_vld_s[DIV_STEPS];
			vld_s32      <= vld_s31;
			out_valid_q  <= vld_s32;
		end
	end

	// Clamp: a magnitude below 64 becomes 64 with the sign kept (zero counts as positive).
	// Anything above 2^32 gives a zero quotient, so it saturates the divisor.
	always_comb begin
		den_neg = denom_s2[DEN_W-1];
		den_mag = den_neg ? DEN_W'(-denom_s2) : DEN_W'(denom_s2);
		if (den_mag < MAG_MIN) begin
			div_d_in = DIV_W'(MIN_MAG);
		end else if (den_mag > DEN_LIMIT) begin
			div_d_in = '1;
		end else begin
			div_d_in = den_mag[DIV_W-1:0];
		end
	end

	assign rnd_x = px_s32 + PROD_W'(ROUND_HALF);
	assign rnd_y = py_s32 + PROD_W'(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1      <= warp_strength_q * in_word.coord_y;
			x_s1         <= in_word.coord_x;
			y_s1         <= in_word.coord_y;

			denom_s2     <= DEN_W'(prod_s1 >>> FRAC_BITS) + DEN_ONE;
			x_s2         <= x_s1;
			y_s2         <= y_s1;

			div_d_s[0]   <= div_d_in;
			div_rem_s[0] <= DIV_W'(INIT_REM);
			div_quo_s[0] <= '0;
			div_neg_s[0] <= den_neg;
			div_x_s[0]   <= x_s2;
			div_y_s[0]   <= y_s2;

			scale_s31    <= div_neg_s[DIV_STEPS] ?
				-signed'({1'b0, div_quo_s[DIV_STEPS]}) :
				signed'({1'b0, div_quo_s[DIV_STEPS]});
			x_s31        <= div_x_s[DIV_STEPS];
			y_s31        <= div_y_s[DIV_STEPS];

			px_s32       <= x_s31 * scale_s31;
			py_s32       <= y_s31 * scale_s31;

			out_word_q.warped_x <= rnd_x[FRAC_BITS +: COORD_W];
			out_word_q.warped_y <= rnd_y[FRAC_BITS +: COORD_W];
		end
	end

	// One restoring step per stage; the dividend's remaining bits are all zero.
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		logic [DIV_W:0]   rem_sh;
		logic             fits;
		logic [DIV_W:0]   rem_nx;

		always_comb begin
			rem_sh = {div_rem_s[j-1], 1'b0};
			fits   = rem_sh >= {1'b0, div_d_s[j-1]};
			rem_nx = fits ? rem_sh - {1'b0, div_d_s[j-1]} : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j] <= 1'b0;
			end else if (adv) begin
				div_vld_s[j] <= div_vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[j] <= rem_nx[DIV_W-1:0];
				div_d_s[j]   <= div_d_s[j-1];
				div_quo_s[j] <= {div_quo_s[j-1][DIV_STEPS-2:0], fits};
				div_neg_s[j] <= div_neg_s[j-1];
				div_x_s[j]   <= div_x_s[j-1];
				div_y_s[j]   <= div_y_s[j-1];
			end
		end
	end

	`PWC_ASSERT_NOW(a_div_min_mag, clk, arst_n, div_vld_s[0], div_d_s[0] >= DIV_W'(MIN_MAG), "divisor below the clamp floor")
	`PWC_ASSERT_NOW(a_rem_below_div, clk, arst_n, div_vld_s[DIV_STEPS], div_rem_s[DIV_STEPS] < div_d_s[DIV_STEPS], "divider remainder not below divisor")
	`PWC_ASSERT_NOW(a_quo_range, clk, arst_n, div_vld_s[DIV_STEPS], div_quo_s[DIV_STEPS] <= QUO_MAX, "quotient above 2^26")
	`PWC_ASSERT_NEXT(a_stall_holds, clk, arst_n, !adv && div_vld_s[0], div_vld_s[0] && $stable(div_d_s[0]), "clamp stage changed during a stall")

endmodule
